/* hw/rtl/hta_pkg.sv */
package hta_pkg;

  localparam int HANDLE_W     = 10;
  localparam int PORT_VALUE_W = 32;
  localparam int COUNT_W      = 11;
  localparam int STATUS_W     = 3;
  localparam int HANDLE_LIMIT = 1024;

  typedef enum logic [1:0] {
    REQ_ALLOC  = 2'd0,
    REQ_FREE   = 2'd1,
    REQ_LOOKUP = 2'd2,
    REQ_COPY   = 2'd3
  } req_type_t;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK         = 3'd0,
    STAT_FULL       = 3'd1,
    STAT_BAD_HANDLE = 3'd2,
    STAT_EMPTY      = 3'd3,
    STAT_ZERO_VALUE = 3'd4
  } status_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic clear_step;
    logic accept;
    logic scan_step;
    logic exec_done;
    logic copy_read;
    logic copy_done;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic clear_last;
    logic out_free;
    logic scan_more;
    logic copy_go;
  } dp_status_t;

endpackage

/* hw/rtl/hta_ram.sv */
module hta_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* hw/rtl/hta_ctrl.sv */
module hta_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  hta_pkg::dp_status_t status,
  output hta_pkg::dp_cmd_t    cmd
);

  typedef enum logic [3:0] {
    ST_CLEAR = 4'b0001,
    ST_IDLE  = 4'b0010,
    ST_EXEC  = 4'b0100,
    ST_COPY  = 4'b1000
  } state_t;

  state_t state_r;
  state_t state_nxt;

  always_comb begin
    cmd       = '0;
    in_ready  = 1'b0;
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR: begin
        cmd.clear_step = 1'b1;
        if (status.clear_last) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = ST_EXEC;
        end
      end
      ST_EXEC: begin
        // Nothing moves while a finished result still occupies the output.
        if (status.out_free) begin
          priority if (status.scan_more) begin
            cmd.scan_step = 1'b1;
          end else if (status.copy_go) begin
            cmd.copy_read = 1'b1;
            state_nxt     = ST_COPY;
          end else begin
            cmd.exec_done = 1'b1;
            state_nxt     = ST_IDLE;
          end
        end
      end
      ST_COPY: begin
        if (status.out_free) begin
          cmd.copy_done = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

/* hw/rtl/hta_dp.sv */
module hta_dp #(
  parameter int TABLE_DEPTH = 1024,
  parameter int VALUE_WIDTH = 32
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  hta_pkg::dp_cmd_t                   cmd,
  output hta_pkg::dp_status_t                status,
  input  logic [1:0]                         in_req_type,
  input  logic [hta_pkg::HANDLE_W-1:0]       in_handle,
  input  logic [hta_pkg::HANDLE_W-1:0]       in_source_handle,
  input  logic [hta_pkg::PORT_VALUE_W-1:0]   in_node_value,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [hta_pkg::HANDLE_W-1:0]       out_handle_out,
  output logic [hta_pkg::PORT_VALUE_W-1:0]   out_value_out,
  output logic [hta_pkg::STATUS_W-1:0]       out_status
);

  localparam int USABLE = (TABLE_DEPTH < hta_pkg::HANDLE_LIMIT) ?
                          TABLE_DEPTH : hta_pkg::HANDLE_LIMIT;
  localparam int AW = $clog2(USABLE);
  localparam int HW = hta_pkg::HANDLE_W;
  localparam int CW = hta_pkg::COUNT_W;
  localparam logic [CW-1:0] USABLE_C = CW'(USABLE);
  localparam logic [CW-1:0] FREE_INIT = CW'(USABLE - 1);
  localparam logic [AW-1:0] CLEAR_LAST = AW'(USABLE - 1);

  function automatic logic [hta_pkg::PORT_VALUE_W-1:0] to_port(
    input logic [VALUE_WIDTH-1:0] v
  );
    logic [63:0] w;
    w = 64'(v);
    return w[hta_pkg::PORT_VALUE_W-1:0];
  endfunction

  // Request registers.
  hta_pkg::req_type_t     req_r;
  logic [HW-1:0]          h_r;
  logic [HW-1:0]          src_r;
  logic [VALUE_WIDTH-1:0] val_r;
  logic [VALUE_WIDTH-1:0] sv_r;

  // Table bookkeeping.
  logic [HW-1:0]          scan_r;
  logic [HW-1:0]          scan_nxt;
  logic [HW-1:0]          rover_r;
  logic [HW-1:0]          rover_nxt;
  logic [CW-1:0]          fc_r;
  logic [CW-1:0]          fc_nxt;
  logic [AW-1:0]          clear_addr_r;

  // Output register.
  logic                   out_valid_r;
  logic [HW-1:0]          out_handle_r;
  logic [hta_pkg::PORT_VALUE_W-1:0] out_value_r;
  hta_pkg::status_t       out_status_r;

  // Memory port.
  logic                   wr_en;
  logic [AW-1:0]          wr_addr;
  logic [VALUE_WIDTH-1:0] wr_data;
  logic                   rd_en;
  logic [AW-1:0]          rd_addr;
  logic [VALUE_WIDTH-1:0] rd_data;

  logic                   load;
  logic [HW-1:0]          res_handle;
  logic [hta_pkg::PORT_VALUE_W-1:0] res_value;
  hta_pkg::status_t       res_status;

  logic                   h_ok;
  logic                   src_ok;
  logic                   val_zero;
  logic                   full;
  logic                   rd_zero;
  logic                   out_free;
  logic [CW-1:0]          scan_inc;
  logic [HW-1:0]          scan_wrap;
  logic [63:0]            node_ext;

  hta_ram #(
    .WIDTH (VALUE_WIDTH),
    .DEPTH (USABLE)
  ) u_slots (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign h_ok     = (h_r != '0) && ({1'b0, h_r} < USABLE_C);
  assign src_ok   = (src_r != '0) && ({1'b0, src_r} < USABLE_C);
  assign val_zero = (val_r == '0);
  assign full     = (fc_r == '0);
  assign rd_zero  = (rd_data == '0);
  assign out_free = !out_valid_r || out_ready;
  assign node_ext = 64'(in_node_value);

  // Next-fit step: the rover wraps from the top of the table back to handle 1.
  assign scan_inc  = {1'b0, scan_r} + CW'(1);
  assign scan_wrap = (scan_inc >= USABLE_C) ? HW'(1) : scan_inc[HW-1:0];

  assign status.clear_last = (clear_addr_r == CLEAR_LAST);
  assign status.out_free   = out_free;
  assign status.scan_more  = (req_r == hta_pkg::REQ_ALLOC) && !val_zero && !full && !rd_zero;
  assign status.copy_go    = (req_r == hta_pkg::REQ_COPY) && h_ok && src_ok;

  always_comb begin
    wr_en      = 1'b0;
    wr_addr    = h_r[AW-1:0];
    wr_data    = '0;
    rd_en      = 1'b0;
    rd_addr    = h_r[AW-1:0];
    fc_nxt     = fc_r;
    rover_nxt  = rover_r;
    scan_nxt   = scan_r;
    load       = 1'b0;
    res_handle = h_r;
    res_value  = '0;
    res_status = hta_pkg::STAT_OK;

    if (cmd.clear_step) begin
      wr_en   = 1'b1;
      wr_addr = clear_addr_r;
    end

    if (cmd.accept) begin
      rd_en    = 1'b1;
      scan_nxt = rover_r;
      priority if (hta_pkg::req_type_t'(in_req_type) == hta_pkg::REQ_ALLOC) begin
        rd_addr = rover_r[AW-1:0];
      end else if (hta_pkg::req_type_t'(in_req_type) == hta_pkg::REQ_COPY) begin
        rd_addr = in_source_handle[AW-1:0];
      end else begin
        rd_addr = in_handle[AW-1:0];
      end
    end

    if (cmd.scan_step) begin
      rd_en    = 1'b1;
      rd_addr  = scan_wrap[AW-1:0];
      scan_nxt = scan_wrap;
    end

    if (cmd.copy_read) begin
      rd_en   = 1'b1;
      rd_addr = h_r[AW-1:0];
    end

    if (cmd.exec_done) begin
      load = 1'b1;
      unique case (req_r)
        hta_pkg::REQ_ALLOC: begin
          res_handle = '0;
          priority if (val_zero) begin
            res_status = hta_pkg::STAT_ZERO_VALUE;
          end else if (full) begin
            res_status = hta_pkg::STAT_FULL;
          end else begin
            res_handle = scan_r;
            res_value  = to_port(val_r);
            wr_en      = 1'b1;
            wr_addr    = scan_r[AW-1:0];
            wr_data    = val_r;
            rover_nxt  = scan_r;
            fc_nxt     = fc_r - CW'(1);
          end
        end
        hta_pkg::REQ_FREE: begin
          priority if (!h_ok) begin
            res_status = hta_pkg::STAT_BAD_HANDLE;
          end else if (rd_zero) begin
            res_status = hta_pkg::STAT_EMPTY;
          end else begin
            wr_en  = 1'b1;
            fc_nxt = fc_r + CW'(1);
          end
        end
        hta_pkg::REQ_LOOKUP: begin
          if (!h_ok) begin
            res_status = hta_pkg::STAT_BAD_HANDLE;
          end else begin
            res_value = to_port(rd_data);
          end
        end
        hta_pkg::REQ_COPY: begin
          // A copy finishes here only when one of its handles is invalid.
          res_status = hta_pkg::STAT_BAD_HANDLE;
        end
        default: begin
          res_status = hta_pkg::STAT_BAD_HANDLE;
        end
      endcase
    end

    if (cmd.copy_done) begin
      // The read data now holds the destination slot's old value.
      load      = 1'b1;
      res_value = to_port(sv_r);
      wr_en     = 1'b1;
      wr_data   = sv_r;
      priority if (rd_zero && (sv_r != '0)) begin
        fc_nxt = fc_r - CW'(1);
      end else if (!rd_zero && (sv_r == '0)) begin
        fc_nxt = fc_r + CW'(1);
      end else begin
        fc_nxt = fc_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fc_r         <= FREE_INIT;
      rover_r      <= HW'(1);
      clear_addr_r <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      fc_r    <= fc_nxt;
      rover_r <= rover_nxt;
      if (cmd.clear_step) begin
        clear_addr_r <= clear_addr_r + AW'(1);
      end
      if (load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    scan_r <= scan_nxt;
    if (cmd.accept) begin
      req_r <= hta_pkg::req_type_t'(in_req_type);
      h_r   <= in_handle;
      src_r <= in_source_handle;
      val_r <= node_ext[VALUE_WIDTH-1:0];
    end
    if (cmd.copy_read) begin
      sv_r <= rd_data;
    end
    if (load) begin
      out_handle_r <= res_handle;
      out_value_r  <= res_value;
      out_status_r <= res_status;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_handle_out = out_handle_r;
  assign out_value_out  = out_value_r;
  assign out_status     = out_status_r;

  a_free_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fc_r <= FREE_INIT)
    else $error("free count exceeds the number of usable slots");

  a_rover_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (rover_r != '0) && ({1'b0, rover_r} < USABLE_C))
    else $error("rover points outside the usable handles");

  a_no_result_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready) |-> !load)
    else $error("result register overwritten before it was taken");

  a_single_port_use: assert property (@(posedge clk) disable iff (!rst_n)
    !(rd_en && wr_en))
    else $error("slot memory read and written in the same cycle");

  a_alloc_into_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.exec_done && (req_r == hta_pkg::REQ_ALLOC) && wr_en) |-> rd_zero)
    else $error("allocate wrote over an occupied slot");

endmodule

/* hw/rtl/handle_table_allocator.sv */
// Handle table allocator: maps handles 1 .. min(TABLE_DEPTH,1024)-1 to nonzero
// values, with zero marking an empty slot. After reset the block sweeps all
// min(TABLE_DEPTH,1024) slots to zero, one slot a cycle, and holds
// in_ready low meanwhile. Lookup and free then read their slot and finish; copy
// reads the source slot, then reads and writes the destination slot, one access
// of the single-ported slot memory per step. Allocate reads the rover's slot
// and one more for each occupied slot its next-fit scan steps over. A finished
// result sits in an output register, so the next request is taken while it
// waits; that request only completes once the output register has been emptied.
module handle_table_allocator #(
  parameter int TABLE_DEPTH = 1024,
  parameter int VALUE_WIDTH = 32
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [1:0]                       in_req_type,
  input  logic [hta_pkg::HANDLE_W-1:0]     in_handle,
  input  logic [hta_pkg::HANDLE_W-1:0]     in_source_handle,
  input  logic [hta_pkg::PORT_VALUE_W-1:0] in_node_value,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [hta_pkg::HANDLE_W-1:0]     out_handle_out,
  output logic [hta_pkg::PORT_VALUE_W-1:0] out_value_out,
  output logic [hta_pkg::STATUS_W-1:0]     out_status
);

  hta_pkg::dp_cmd_t    cmd;
  hta_pkg::dp_status_t status;

  hta_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  hta_dp #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .status           (status),
    .in_req_type      (in_req_type),
    .in_handle        (in_handle),
    .in_source_handle (in_source_handle),
    .in_node_value    (in_node_value),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_handle_out   (out_handle_out),
    .out_value_out    (out_value_out),
    .out_status       (out_status)
  );

endmodule
